@@ sv/gvsn_pkg.sv @@
// shared types and constants for the grid vertex star neighbor block
package gvsn_pkg;

    localparam int DIM_W       = 11;
    localparam int VTX_W       = 30;
    localparam int NB_CNT      = 14;
    localparam int IDX_W       = $clog2(NB_CNT);
    localparam int STEP_CNT    = NB_CNT / 2;
    localparam int STEP_W      = 21;
    localparam int PROD_W      = 2 * DIM_W;
    localparam int MAX_DIM_DEF = 1024;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam int DIV_W    = 32;
    localparam int DIV_STEP = 4;
    localparam int DIVA_LEN = DIV_W;
    localparam int DIVB_LEN = 20;
    localparam int DIVA_CYC = DIVA_LEN / DIV_STEP;
    localparam int DIVB_CYC = DIVB_LEN / DIV_STEP;
    localparam int CNT_W    = $clog2(DIVA_CYC);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIVA = 4'b0010,
        ST_DIVB = 4'b0100,
        ST_PUSH = 4'b1000
    } t_front_state;

    typedef struct packed {
        logic [DIM_W-1:0]                 size_x;
        logic [DIM_W-1:0]                 size_y;
        logic [DIM_W-1:0]                 size_z;
        logic [STEP_W-1:0]                syz;
        logic [STEP_CNT-1:0][STEP_W-1:0]  step;
    } t_geom;

    typedef struct packed {
        logic [VTX_W-1:0]  vertex;
        logic [NB_CNT-1:0] mask;
        logic              oog;
    } t_entry;

endpackage

@@ sv/gvsn_front.sv @@
// front part: takes a vertex, splits it into x, y, z and builds its neighbor mask
module gvsn_front
    import gvsn_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [VTX_W-1:0] i_vertex,
    input  t_geom          i_geom,
    input  logic           i_full,
    output logic           o_push,
    output t_entry         o_entry
);

    t_front_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIM_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [VTX_W-1:0] r_v, n_v;
    logic [DIM_W-1:0] r_x, n_x;
    logic [DIM_W-1:0] r_y, n_y;
    logic [DIM_W-1:0] r_z, n_z;
    logic             r_oog, n_oog;

    logic [DIM_W-1:0] div_d;
    logic [DIM_W-1:0] s_rem;
    logic [DIV_W-1:0] s_quo;
    logic [DIM_W:0]   div_t;
    logic             accept;
    logic             oog_chk;
    logic             xp, xm, yp, ym, zp, zm;
    logic [NB_CNT-1:0] mask;

    // four restoring divide steps per cycle
    always_comb begin
        div_d = (r_state == ST_DIVB) ? i_geom.size_y : i_geom.size_x;
        s_rem = r_rem;
        s_quo = r_quo;
        div_t = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            div_t = {s_rem, s_quo[DIV_W-1]};
            s_quo = {s_quo[DIV_W-2:0], 1'b0};
            if (div_t >= {1'b0, div_d}) begin
                s_rem    = DIM_W'(div_t - {1'b0, div_d});
                s_quo[0] = 1'b1;
            end else begin
                s_rem = div_t[DIM_W-1:0];
            end
        end
    end

    assign oog_chk = (i_geom.size_x == '0) || (i_geom.size_y == '0) ||
                     (i_geom.size_z == '0) ||
                     (s_quo >= {{(DIV_W-STEP_W){1'b0}}, i_geom.syz});

    assign o_push = (r_state == ST_PUSH) && !i_full;
    assign busy   = !((r_state == ST_IDLE) || o_push);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_v     = r_v;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_oog   = r_oog;
        unique case (r_state)
            ST_IDLE, ST_PUSH: begin
                if (accept) begin
                    n_v     = i_vertex;
                    n_quo   = {{(DIV_W-VTX_W){1'b0}}, i_vertex};
                    n_rem   = '0;
                    n_cnt   = CNT_W'(DIVA_CYC - 1);
                    n_state = ST_DIVA;
                end else if (o_push) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIVA: begin
                n_rem = s_rem;
                n_quo = s_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_x   = s_rem;
                    n_oog = oog_chk;
                    if (oog_chk) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_quo   = {s_quo[DIVB_LEN-1:0], {(DIV_W-DIVB_LEN){1'b0}}};
                        n_rem   = '0;
                        n_cnt   = CNT_W'(DIVB_CYC - 1);
                        n_state = ST_DIVB;
                    end
                end
            end
            ST_DIVB: begin
                n_rem = s_rem;
                n_quo = s_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_y     = s_rem;
                    n_z     = s_quo[DIM_W-1:0];
                    n_state = ST_PUSH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // neighbor mask in fixed listed order
    always_comb begin
        xp = ({1'b0, r_x} + 1'b1) < {1'b0, i_geom.size_x};
        yp = ({1'b0, r_y} + 1'b1) < {1'b0, i_geom.size_y};
        zp = ({1'b0, r_z} + 1'b1) < {1'b0, i_geom.size_z};
        xm = (r_x != '0);
        ym = (r_y != '0);
        zm = (r_z != '0);
        mask = {xm & ym & zm, xp & yp & zp,
                ym & zm,      yp & zp,
                xm & zm,      xp & zp,
                xm & ym,      xp & yp,
                zm, zp, ym, yp, xm, xp};
    end

    assign o_entry.vertex = r_v;
    assign o_entry.mask   = r_oog ? '0 : mask;
    assign o_entry.oog    = r_oog;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_v   <= n_v;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_oog <= n_oog;
    end

endmodule

@@ sv/gvsn_queue.sv @@
// short queue of classified items between the front and back parts
module gvsn_queue
    import gvsn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_entry r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule

@@ sv/gvsn_back.sv @@
// back part: walks the neighbor mask of each item and emits one result per cycle while the queue supplies items
module gvsn_back
    import gvsn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_geom            i_geom,
    input  t_entry           i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [VTX_W-1:0] o_neighbor,
    output logic             o_neighbor_valid,
    output logic             o_last_of_run,
    output logic             o_out_of_grid
);

    logic              r_active, n_active;
    logic [VTX_W-1:0]  r_v, n_v;
    logic [NB_CNT-1:0] r_mask, n_mask;
    logic              r_oog, n_oog;

    logic              r_strobe;
    logic [VTX_W-1:0]  r_neighbor, n_neighbor;
    logic              r_valid, n_valid;
    logic              r_last, n_last;
    logic              r_oog_out, n_oog_out;

    logic [IDX_W-1:0]  idx;
    logic [NB_CNT-1:0] rest;
    logic [STEP_W-1:0] step_mag;
    logic [VTX_W-1:0]  nb;
    logic              finishing;

    always_comb begin
        idx = '0;
        for (int i = NB_CNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign rest      = r_mask & (r_mask - 1'b1);
    assign step_mag  = i_geom.step[idx[IDX_W-1:1]];
    assign nb        = idx[0] ? (r_v - VTX_W'(step_mag)) : (r_v + VTX_W'(step_mag));
    assign finishing = r_active && ((r_mask == '0) || (rest == '0));
    assign o_pop     = !i_empty && (!r_active || finishing);

    always_comb begin
        n_active = r_active;
        n_v      = r_v;
        n_mask   = r_mask;
        n_oog    = r_oog;
        if (o_pop) begin
            n_active = 1'b1;
            n_v      = i_entry.vertex;
            n_mask   = i_entry.mask;
            n_oog    = i_entry.oog;
        end else if (finishing) begin
            n_active = 1'b0;
        end else if (r_active) begin
            n_mask = rest;
        end
    end

    always_comb begin
        if (r_mask == '0) begin
            n_neighbor = '0;
            n_valid    = 1'b0;
            n_last     = 1'b1;
            n_oog_out  = r_oog;
        end else begin
            n_neighbor = nb;
            n_valid    = 1'b1;
            n_last     = (rest == '0);
            n_oog_out  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_mask     <= n_mask;
        r_oog      <= n_oog;
        r_neighbor <= n_neighbor;
        r_valid    <= n_valid;
        r_last     <= n_last;
        r_oog_out  <= n_oog_out;
    end

    assign o_strobe         = r_strobe;
    assign o_neighbor       = r_neighbor;
    assign o_neighbor_valid = r_valid;
    assign o_last_of_run    = r_last;
    assign o_out_of_grid    = r_oog_out;

`ifndef SYNTH
    a_valid_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_neighbor_valid) |-> !o_out_of_grid)
        else $error("real neighbor flagged out of grid");

    a_oog_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_of_grid) |-> o_last_of_run)
        else $error("out of grid result not last of run");

    a_empty_mask_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && (r_mask == '0)) |=> (o_strobe && o_last_of_run && !o_neighbor_valid))
        else $error("empty mask item did not give one closing result");
`endif

endmodule

@@ sv/grid_vertex_star_neighbors_core.sv @@
// top level of the grid vertex star neighbor block with configuration registers
//
// usage: write size_x, size_y, size_z (index 0, 1, 2) on the config channel while
// idle; o_cfg_ready is always high and values above MAX_DIM are clamped to it.
// an item (i_vertex) is taken at a clock edge with start high and busy low.
// the front splits the vertex into x, y, z with a shared divider retiring four
// quotient bits per cycle: first the x split, then the y/z split (skipped when
// out of grid), then a hand-off state; busy stays high until the item is pushed
// to the queue, so the front holds one item at a time. a two-entry queue sits
// between front and back; the back emits one result per cycle on o_strobe while
// the queue supplies items, walking the neighbor mask in the fixed offset order.
// a vertex with k neighbors gives k results on consecutive cycles, the last marked
// by o_last_of_run. an index past the grid, or a vertex with no neighbor, gives
// one result with o_neighbor_valid low (and o_out_of_grid high for the former).
// results cannot be held off: each is on the ports for exactly one cycle.
// synchronous reset clears all control state and sets all sizes to 1.
module grid_vertex_star_neighbors_core
    import gvsn_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [VTX_W-1:0]     i_vertex,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [VTX_W-1:0]     o_neighbor,
    output logic                 o_neighbor_valid,
    output logic                 o_last_of_run,
    output logic                 o_out_of_grid
);

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic [STEP_W-1:0] r_plane, r_syz;
    logic [STEP_CNT-1:0][STEP_W-1:0] r_step;
    logic [DIM_W-1:0]  cfg_clamped;
    logic [PROD_W-1:0] prod_xy, prod_yz;
    logic [STEP_W-1:0] sx_ext;

    t_geom  geom;
    t_entry push_entry, pop_entry;
    logic   q_push, q_pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;
    assign cfg_clamped = (i_cfg_data > MAX_DIM_V) ? MAX_DIM_V : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= DIM_W'(1);
            r_size_y <= DIM_W'(1);
            r_size_z <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= cfg_clamped;
                CFG_SIZE_Y: r_size_y <= cfg_clamped;
                CFG_SIZE_Z: r_size_z <= cfg_clamped;
                default: begin
                end
            endcase
        end
    end

    assign prod_xy = {{DIM_W{1'b0}}, r_size_x} * {{DIM_W{1'b0}}, r_size_y};
    assign prod_yz = {{DIM_W{1'b0}}, r_size_y} * {{DIM_W{1'b0}}, r_size_z};
    assign sx_ext  = {{(STEP_W-DIM_W){1'b0}}, r_size_x};

    always_ff @(posedge i_clk) begin
        r_plane   <= prod_xy[STEP_W-1:0];
        r_syz     <= prod_yz[STEP_W-1:0];
        r_step[0] <= STEP_W'(1);
        r_step[1] <= sx_ext;
        r_step[2] <= r_plane;
        r_step[3] <= sx_ext + 1'b1;
        r_step[4] <= r_plane + 1'b1;
        r_step[5] <= sx_ext + r_plane;
        r_step[6] <= sx_ext + r_plane + 1'b1;
    end

    assign geom.size_x = r_size_x;
    assign geom.size_y = r_size_y;
    assign geom.size_z = r_size_z;
    assign geom.syz    = r_syz;
    assign geom.step   = r_step;

    gvsn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_vertex(i_vertex),
        .i_geom  (geom),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (push_entry)
    );

    gvsn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (pop_entry),
        .o_empty (q_empty)
    );

    gvsn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_geom          (geom),
        .i_entry         (pop_entry),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_strobe        (o_strobe),
        .o_neighbor      (o_neighbor),
        .o_neighbor_valid(o_neighbor_valid),
        .o_last_of_run   (o_last_of_run),
        .o_out_of_grid   (o_out_of_grid)
    );

endmodule

@@ verif/grid_vertex_star_neighbors_core_tb.sv @@
// self-checking testbench for the grid vertex star neighbor core
`timescale 1ns / 100ps

module grid_vertex_star_neighbors_core_tb;
    import gvsn_pkg::*;

    typedef struct packed {
        logic [VTX_W-1:0] neighbor;
        logic             valid;
        logic             last;
        logic             oog;
    } t_star_result;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [VTX_W-1:0]     VTX_MAX   = {VTX_W{1'b1}};
    localparam int                   CYCLE_LIMIT = 300000;
    localparam int                   TAIL_CYCLES = 40;
    // direction of each offset pair, bit 0 = x, bit 1 = y, bit 2 = z
    localparam logic [STEP_CNT-1:0][2:0] STEP_DIRS =
        {3'b111, 3'b110, 3'b101, 3'b011, 3'b100, 3'b010, 3'b001};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic [VTX_W-1:0]     i_vertex    = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 busy;
    logic                 o_cfg_ready;
    logic                 o_strobe;
    logic [VTX_W-1:0]     o_neighbor;
    logic                 o_neighbor_valid;
    logic                 o_last_of_run;
    logic                 o_out_of_grid;

    logic [VTX_W-1:0] vtx_pending[$];
    t_star_result     star_q[$];
    int unsigned      dim_x = 1;
    int unsigned      dim_y = 1;
    int unsigned      dim_z = 1;
    int               err_cnt = 0;
    int               cycle_cnt = 0;
    int               gap_left = 0;
    logic             drain_hold = 1'b0;
    logic             idle_on = 1'b1;
    logic             item_fired = 1'b0;
    logic             cfg_fired = 1'b0;

    grid_vertex_star_neighbors_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_vertex         (i_vertex),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_neighbor       (o_neighbor),
        .o_neighbor_valid (o_neighbor_valid),
        .o_last_of_run    (o_last_of_run),
        .o_out_of_grid    (o_out_of_grid)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_star_result mk_result(input logic [VTX_W-1:0] nb, input logic valid,
                                               input logic last, input logic oog);
        t_star_result r;
        r.neighbor = nb;
        r.valid    = valid;
        r.last     = last;
        r.oog      = oog;
        return r;
    endfunction

    function automatic void predict_star(input logic [VTX_W-1:0] vtx);
        longint       sx, sy, sz, plane, total, v, x, y, z, nx, ny, nz, sgn;
        int           found;
        logic [2:0]   dir;
        t_star_result hits[NB_CNT];
        sx = dim_x;
        sy = dim_y;
        sz = dim_z;
        plane = sx * sy;
        total = plane * sz;
        v = vtx;
        found = 0;
        if (v >= total) begin
            star_q.push_back(mk_result('0, 1'b0, 1'b1, 1'b1));
        end else begin
            x = v % sx;
            y = (v / sx) % sy;
            z = v / plane;
            for (int i = 0; i < NB_CNT; i++) begin
                dir = STEP_DIRS[i / 2];
                sgn = (i % 2) ? -1 : 1;
                nx = x + (dir[0] ? sgn : 0);
                ny = y + (dir[1] ? sgn : 0);
                nz = z + (dir[2] ? sgn : 0);
                if (nx >= 0 && nx < sx && ny >= 0 && ny < sy && nz >= 0 && nz < sz) begin
                    hits[found] = mk_result(VTX_W'(nx + ny * sx + nz * plane), 1'b1, 1'b0, 1'b0);
                    found++;
                end
            end
            if (found == 0) begin
                star_q.push_back(mk_result('0, 1'b0, 1'b1, 1'b0));
            end else begin
                hits[found-1].last = 1'b1;
                for (int i = 0; i < found; i++) star_q.push_back(hits[i]);
            end
        end
    endfunction

    // monitor: results, accepted items and register writes
    always @(posedge i_clk) begin : watch_outputs
        t_star_result exp_r;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else if (!i_rst_n) begin
            dim_x = 1;
            dim_y = 1;
            dim_z = 1;
        end else begin
            if (o_strobe) begin
                if (star_q.size() == 0) begin
                    $error("neighbor result with none expected: neighbor %0d", o_neighbor);
                    err_cnt++;
                end else begin
                    exp_r = star_q.pop_front();
                    if (o_neighbor !== exp_r.neighbor) begin
                        $error("neighbor: expected %0d, got %0d", exp_r.neighbor, o_neighbor);
                        err_cnt++;
                    end
                    if (o_neighbor_valid !== exp_r.valid) begin
                        $error("neighbor_valid: expected %0b, got %0b",
                               exp_r.valid, o_neighbor_valid);
                        err_cnt++;
                    end
                    if (o_last_of_run !== exp_r.last) begin
                        $error("last_of_run: expected %0b, got %0b", exp_r.last, o_last_of_run);
                        err_cnt++;
                    end
                    if (o_out_of_grid !== exp_r.oog) begin
                        $error("out_of_grid: expected %0b, got %0b", exp_r.oog, o_out_of_grid);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                predict_star(i_vertex);
                item_fired = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SIZE_X: dim_x = (i_cfg_data > MAX_DIM_DEF) ? MAX_DIM_DEF : i_cfg_data;
                    CFG_SIZE_Y: dim_y = (i_cfg_data > MAX_DIM_DEF) ? MAX_DIM_DEF : i_cfg_data;
                    CFG_SIZE_Z: dim_z = (i_cfg_data > MAX_DIM_DEF) ? MAX_DIM_DEF : i_cfg_data;
                    default: ;
                endcase
                cfg_fired = 1'b1;
            end
        end
    end

    // driver: presents pending items with random gaps and drain pauses
    always @(negedge i_clk) begin : drive_items
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_fired) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (drain_hold) begin
                if (star_q.size() == 0) drain_hold = 1'b0;
                start <= 1'b0;
            end else if (vtx_pending.size() > 0) begin
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 11);
                    start <= 1'b0;
                end else if (idle_on && $urandom_range(0, 79) == 0) begin
                    drain_hold = 1'b1;
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_vertex <= vtx_pending.pop_front();
                end
            end else begin
                start <= 1'b0;
            end
        end
        item_fired = 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        cfg_fired = 1'b0;
        do @(negedge i_clk); while (!cfg_fired);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (vtx_pending.size() > 0 || start || star_q.size() > 0 || busy);
    endtask

    function automatic logic [VTX_W-1:0] vtx_at(input longint x, input longint y,
                                                 input longint z);
        return VTX_W'(x + y * dim_x + z * dim_x * dim_y);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return DIM_W'($urandom_range(1, 6));
        if (sel < 80) return DIM_W'(1);
        if (sel < 90) return DIM_W'($urandom_range(7, MAX_DIM_DEF));
        if (sel < 95) return DIM_W'(0);
        return DIM_W'($urandom_range(MAX_DIM_DEF + 1, 2047));
    endfunction

    function automatic logic [VTX_W-1:0] pick_vertex();
        longint      total, pv;
        int unsigned sel;
        total = longint'(dim_x) * dim_y * dim_z;
        sel = $urandom_range(0, 99);
        if (total == 0 || sel < 15) return VTX_W'($urandom);
        if (sel < 25) begin
            pv = total + $urandom_range(0, 3);
            return (pv > VTX_MAX) ? VTX_MAX : VTX_W'(pv);
        end
        if (sel < 45) begin
            return vtx_at($urandom_range(0, 1) ? 0 : dim_x - 1,
                          $urandom_range(0, 1) ? $urandom_range(0, dim_y - 1) : dim_y - 1,
                          $urandom_range(0, 1) ? 0 : $urandom_range(0, dim_z - 1));
        end
        return VTX_W'($urandom_range(0, int'(total - 1)));
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset sizes: single vertex grid
        vtx_pending.push_back('0);
        vtx_pending.push_back(VTX_W'(1));
        vtx_pending.push_back(VTX_MAX);
        drain();

        // largest grid, size_z above the clamp
        write_reg(CFG_SIZE_X, DIM_W'(MAX_DIM_DEF));
        write_reg(CFG_SIZE_Y, DIM_W'(MAX_DIM_DEF));
        write_reg(CFG_SIZE_Z, DIM_W'(2047));
        vtx_pending.push_back('0);
        vtx_pending.push_back(VTX_MAX);
        vtx_pending.push_back(vtx_at(512, 512, 512));
        vtx_pending.push_back(vtx_at(1023, 0, 0));
        vtx_pending.push_back(vtx_at(0, 1023, 1023));
        vtx_pending.push_back(30'h2AAAAAAA);
        vtx_pending.push_back(30'h15555555);
        drain();

        // zero size: empty grid; spare index is ignored
        write_reg(CFG_SIZE_Y, '0);
        write_reg(CFG_SPARE, DIM_W'(2047));
        vtx_pending.push_back('0);
        vtx_pending.push_back(VTX_W'(5));
        drain();

        // 3x3x3: center has all neighbors
        write_reg(CFG_SIZE_X, DIM_W'(3));
        write_reg(CFG_SIZE_Y, DIM_W'(3));
        write_reg(CFG_SIZE_Z, DIM_W'(3));
        vtx_pending.push_back(VTX_W'(13));
        vtx_pending.push_back('0);
        vtx_pending.push_back(VTX_W'(26));
        vtx_pending.push_back(VTX_W'(27));
        vtx_pending.push_back(vtx_at(1, 0, 2));
        drain();

        write_reg(CFG_SIZE_X, DIM_W'(2));
        write_reg(CFG_SIZE_Y, DIM_W'(1));
        write_reg(CFG_SIZE_Z, DIM_W'(1));
        vtx_pending.push_back('0);
        vtx_pending.push_back(VTX_W'(1));
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 11) idle_on = 1'b0;
            write_reg(CFG_SIZE_X, pick_dim());
            write_reg(CFG_SIZE_Y, pick_dim());
            write_reg(CFG_SIZE_Z, pick_dim());
            for (int n = 0; n < 38; n++) vtx_pending.push_back(pick_vertex());
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (star_q.size() != 0) begin
            $error("neighbor results still expected at end: %0d", star_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
